FILE: src/stt_pkg.sv
package stt_pkg;

	// Result queue sizing: room for two beats in flight plus two more.
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int QUEUE_ROOM  = QUEUE_DEPTH - 4;

	// Token kinds.
	localparam logic [4:0] K_EOF     = 5'd0;
	localparam logic [4:0] K_IDENT   = 5'd1;
	localparam logic [4:0] K_INT     = 5'd2;
	localparam logic [4:0] K_FLOAT   = 5'd3;
	localparam logic [4:0] K_STRING  = 5'd4;
	localparam logic [4:0] K_FN      = 5'd5;
	localparam logic [4:0] K_IF      = 5'd6;
	localparam logic [4:0] K_ELSE    = 5'd7;
	localparam logic [4:0] K_WHILE   = 5'd8;
	localparam logic [4:0] K_RETURN  = 5'd9;
	localparam logic [4:0] K_PLUS    = 5'd10;
	localparam logic [4:0] K_MINUS   = 5'd11;
	localparam logic [4:0] K_STAR    = 5'd12;
	localparam logic [4:0] K_SLASH   = 5'd13;
	localparam logic [4:0] K_LPAREN  = 5'd14;
	localparam logic [4:0] K_RPAREN  = 5'd15;
	localparam logic [4:0] K_LBRACK  = 5'd16;
	localparam logic [4:0] K_RBRACK  = 5'd17;
	localparam logic [4:0] K_COMMA   = 5'd18;
	localparam logic [4:0] K_SEMI    = 5'd19;
	localparam logic [4:0] K_LBRACE  = 5'd20;
	localparam logic [4:0] K_RBRACE  = 5'd21;
	localparam logic [4:0] K_ASSIGN  = 5'd22;
	localparam logic [4:0] K_EQ      = 5'd23;
	localparam logic [4:0] K_NE      = 5'd24;
	localparam logic [4:0] K_LE      = 5'd25;
	localparam logic [4:0] K_GE      = 5'd26;
	localparam logic [4:0] K_ANDAND  = 5'd27;
	localparam logic [4:0] K_OROR    = 5'd28;
	localparam logic [4:0] K_LT      = 5'd29;
	localparam logic [4:0] K_GT      = 5'd30;
	localparam logic [4:0] K_BANG    = 5'd31;

	// Keywords packed first byte lowest, zero padded to six bytes.
	localparam logic [47:0] KW_FN     = 48'h0000_0000_6E66;
	localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
	localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6C65;
	localparam logic [47:0] KW_WHILE  = 48'h0065_6C69_6877;
	localparam logic [47:0] KW_RETURN = 48'h6E72_7574_6572;

	// Lexer modes.
	typedef enum logic [11:0] {
		M_IDLE    = 12'b0000_0000_0001,
		M_IDENT   = 12'b0000_0000_0010,
		M_INT     = 12'b0000_0000_0100,
		M_FLOAT   = 12'b0000_0000_1000,
		M_STRING  = 12'b0000_0001_0000,
		M_COLON   = 12'b0000_0010_0000,
		M_EQUAL   = 12'b0000_0100_0000,
		M_BANG    = 12'b0000_1000_0000,
		M_LESS    = 12'b0001_0000_0000,
		M_GREATER = 12'b0010_0000_0000,
		M_AMP     = 12'b0100_0000_0000,
		M_BAR     = 12'b1000_0000_0000
	} mode_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic        last;
	} token_t;

	// Which of the two token slots a processed byte fills.
	typedef struct packed {
		logic a_valid;
		logic b_valid;
	} push_t;

endpackage

FILE: src/stt_channels.sv
interface stt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface stt_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] lexeme_start;
	logic [15:0] lexeme_length;
	logic [15:0] line_number;
	logic        last_of_run;

	modport source (output valid, output token_kind, output lexeme_start,
		output lexeme_length, output line_number, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input lexeme_start,
		input lexeme_length, input line_number, input last_of_run, output ready);
endinterface

FILE: src/stt_lexer.sv
module stt_lexer #(
	parameter int POSITION_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     char_in,
	output stt_pkg::push_t push,
	output stt_pkg::token_t tok_a,
	output stt_pkg::token_t tok_b
);
	import stt_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic                     valid_s1;
	logic [7:0]               char_s1;
	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d, begin_q, begin_d, pos_inc, len_w;
	logic [15:0]              line_q, line_d;
	logic [47:0]              prefix_q, prefix_d;
	logic [31:0]              len32;
	logic [15:0]              start16, pos16;
	logic                     fl_valid;
	logic [4:0]               fl_kind, fr_kind, pair;
	logic                     do_flush, do_fresh, a_v, b_v;

	function automatic logic [15:0] clamp16(input logic [31:0] v);
		return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alp(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic [4:0] single_op(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"/": k = K_SLASH;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			",": k = K_COMMA;
			";": k = K_SEMI;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			default: k = K_EOF;
		endcase
		return k;
	endfunction

	function automatic mode_t op_mode(input logic [7:0] c);
		mode_t m;
		case (c)
			":": m = M_COLON;
			"=": m = M_EQUAL;
			"!": m = M_BANG;
			"<": m = M_LESS;
			">": m = M_GREATER;
			"&": m = M_AMP;
			"|": m = M_BAR;
			default: m = M_IDLE;
		endcase
		return m;
	endfunction

	// Kind of a two-character operator, EOF when the pair does not combine.
	function automatic logic [4:0] pair_kind(input mode_t m, input logic [7:0] c);
		logic [4:0] k;
		k = K_EOF;
		if (c == "=") begin
			case (m)
				M_COLON:   k = K_ASSIGN;
				M_EQUAL:   k = K_EQ;
				M_BANG:    k = K_NE;
				M_LESS:    k = K_LE;
				M_GREATER: k = K_GE;
				default:   k = K_EOF;
			endcase
		end else if ((c == "&") && (m == M_AMP)) begin
			k = K_ANDAND;
		end else if ((c == "|") && (m == M_BAR)) begin
			k = K_OROR;
		end
		return k;
	endfunction

	function automatic logic [4:0] ident_kind(input logic [31:0] len,
			input logic [47:0] pre);
		logic [4:0] k;
		k = K_IDENT;
		if ((len == 32'd2) && (pre == KW_FN)) k = K_FN;
		else if ((len == 32'd2) && (pre == KW_IF)) k = K_IF;
		else if ((len == 32'd4) && (pre == KW_ELSE)) k = K_ELSE;
		else if ((len == 32'd5) && (pre == KW_WHILE)) k = K_WHILE;
		else if ((len == 32'd6) && (pre == KW_RETURN)) k = K_RETURN;
		return k;
	endfunction

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= char_in;
		end
	end

	// Shared position arithmetic.
	assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign len_w   = (pos_q >= begin_q) ? pos_q - begin_q : '0;
	assign len32   = 32'(len_w);
	assign start16 = clamp16(32'(begin_q));
	assign pos16   = clamp16(32'(pos_q));
	assign fr_kind = single_op(char_s1);
	assign pair    = pair_kind(mode_q, char_s1);

	// Token held by the current mode, ending before this byte.
	always_comb begin
		fl_valid = 1'b1;
		fl_kind  = K_EOF;
		case (mode_q)
			M_IDENT:   fl_kind = ident_kind(len32, prefix_q);
			M_INT:     fl_kind = K_INT;
			M_FLOAT:   fl_kind = K_FLOAT;
			M_STRING:  fl_kind = K_STRING;
			M_BANG:    fl_kind = K_BANG;
			M_LESS:    fl_kind = K_LT;
			M_GREATER: fl_kind = K_GT;
			default:   fl_valid = 1'b0;
		endcase
	end

	// Byte classification against the current mode.
	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_inc;
		begin_d  = begin_q;
		line_d   = line_q;
		prefix_d = prefix_q;
		do_flush = 1'b0;
		do_fresh = 1'b0;
		a_v      = 1'b0;
		b_v      = 1'b0;
		tok_a    = '{kind: fl_kind, start: start16, length: clamp16(len32),
			line: line_q, last: 1'b0};
		tok_b    = '{kind: fr_kind, start: pos16, length: 16'd1,
			line: line_q, last: 1'b1};

		if (char_s1 == 8'd0) begin
			do_flush = 1'b1;
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_alp(char_s1) || is_dig(char_s1)) begin
						if ((pos_q >= begin_q) && (len32 < 32'd6)) begin
							prefix_d[8*len_w[2:0] +: 8] = prefix_q[8*len_w[2:0] +: 8] | char_s1;
						end
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_INT: begin
					if (char_s1 == ".") begin
						mode_d = M_FLOAT;
					end else if (!is_dig(char_s1)) begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_FLOAT: begin
					if (!is_dig(char_s1)) begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				M_STRING: begin
					if (char_s1 == "\"") begin
						do_flush = 1'b1;
					end
				end
				M_COLON, M_EQUAL, M_BANG, M_LESS, M_GREATER, M_AMP, M_BAR: begin
					if (pair != K_EOF) begin
						a_v          = 1'b1;
						tok_a.kind   = pair;
						tok_a.length = 16'd2;
						mode_d       = M_IDLE;
					end else begin
						do_flush = 1'b1;
						do_fresh = 1'b1;
					end
				end
				default: begin
					do_fresh = 1'b1;
				end
			endcase
		end

		// Pending token leaves first.
		if (do_flush) begin
			a_v    = fl_valid;
			mode_d = M_IDLE;
			if ((mode_q == M_BANG) || (mode_q == M_LESS) || (mode_q == M_GREATER)) begin
				tok_a.length = 16'd1;
			end
		end

		// The byte then starts whatever it begins.
		if (do_fresh) begin
			mode_d = M_IDLE;
			if (char_s1 == "\n") begin
				line_d = (line_q == 16'hFFFF) ? line_q : line_q + 16'd1;
			end else if (fr_kind != K_EOF) begin
				b_v = 1'b1;
			end else if (char_s1 == "\"") begin
				mode_d  = M_STRING;
				begin_d = pos_inc;
			end else if (is_dig(char_s1)) begin
				mode_d  = M_INT;
				begin_d = pos_q;
			end else if (is_alp(char_s1)) begin
				mode_d   = M_IDENT;
				begin_d  = pos_q;
				prefix_d = {40'd0, char_s1};
			end else begin
				mode_d  = op_mode(char_s1);
				begin_d = pos_q;
			end
		end

		// End of source: end-of-file token and return to the reset state.
		if (char_s1 == 8'd0) begin
			b_v          = 1'b1;
			tok_b.kind   = K_EOF;
			tok_b.length = 16'd0;
			mode_d       = M_IDLE;
			pos_d        = '0;
			begin_d      = '0;
			line_d       = 16'd1;
			prefix_d     = '0;
		end

		tok_a.last = !b_v;
		push       = '{a_valid: valid_s1 && a_v, b_valid: valid_s1 && b_v};
	end

	// Lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			begin_q  <= '0;
			line_q   <= 16'd1;
			prefix_q <= '0;
		end else if (valid_s1) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			begin_q  <= begin_d;
			line_q   <= line_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

FILE: src/stt_queue.sv
module stt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  stt_pkg::push_t  push,
	input  stt_pkg::token_t tok_a,
	input  stt_pkg::token_t tok_b,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output stt_pkg::token_t out_tok
);
	import stt_pkg::*;

	token_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_q, rd_q, wr_b;
	logic [QCNT_BITS-1:0]   count_q, n_push;
	logic                   pop;

	assign pop       = out_valid && out_ready;
	assign n_push    = QCNT_BITS'(push.a_valid) + QCNT_BITS'(push.b_valid);
	assign wr_b      = wr_q + QPTR_BITS'(push.a_valid);
	assign out_valid = (count_q != '0);
	assign out_tok   = mem_q[rd_q];
	assign room      = (count_q <= QCNT_BITS'(QUEUE_ROOM));

	// Token storage, up to two beats written per cycle.
	always_ff @(posedge clk) begin
		if (push.a_valid) begin
			mem_q[wr_q] <= tok_a;
		end
		if (push.b_valid) begin
			mem_q[wr_b] <= tok_b;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_BITS'(n_push);
			rd_q    <= rd_q + QPTR_BITS'(pop);
			count_q <= count_q + n_push - QCNT_BITS'(pop);
		end
	end

endmodule

FILE: src/source_text_tokenizer.sv
// A byte accepted into the input register is lexed in the next cycle; its tokens
// are written into the token queue, from which they can then be taken.
// Throughput: one byte per cycle while the 8-entry token queue holds at most
// four beats; tokens leave at one per cycle while out_ready is high, so a byte
// that yields two tokens borrows queue space that later bytes give back.
// Reset: arst_n clears the lexer to idle, position 0, line 1, and empties the queue.
module source_text_tokenizer #(
	parameter int POSITION_BITS = 16
) (
	input logic         clk,
	input logic         arst_n,
	stt_text_if.sink    text,
	stt_token_if.source tokens
);
	import stt_pkg::*;

	push_t  push;
	token_t tok_a, tok_b, out_tok;
	logic   room;

	// Accept a byte whenever the queue can absorb two beats from it.
	assign text.ready = room;

	stt_lexer #(
		.POSITION_BITS(POSITION_BITS)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (text.valid && room),
		.char_in(text.char_code),
		.push   (push),
		.tok_a  (tok_a),
		.tok_b  (tok_b)
	);

	stt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.tok_a    (tok_a),
		.tok_b    (tok_b),
		.room     (room),
		.out_valid(tokens.valid),
		.out_ready(tokens.ready),
		.out_tok  (out_tok)
	);

	assign tokens.token_kind    = out_tok.kind;
	assign tokens.lexeme_start  = out_tok.start;
	assign tokens.lexeme_length = out_tok.length;
	assign tokens.line_number   = out_tok.line;
	assign tokens.last_of_run   = out_tok.last;

endmodule

FILE: src/stt_checker.sv
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  kind,
	input logic [15:0] length,
	input logic [15:0] line,
	input logic        last
);
	import stt_pkg::*;

	// The end-of-file beat is empty and closes its run.
	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == K_EOF)) |-> ((length == 16'd0) && last))
		else $error("end-of-file beat with length or not last");

	// Two-character operators always span two bytes.
	a_pair_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind >= K_ASSIGN) && (kind <= K_OROR)) |-> (length == 16'd2))
		else $error("two-character operator with wrong length");

	// Line numbers start at one and never wrap to zero.
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (line != 16'd0))
		else $error("line number zero");

	// Both tokens of one byte are queued together, so the second follows at once.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("run broken after a non-final beat");

endmodule

bind source_text_tokenizer stt_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(tokens.valid),
	.out_ready(tokens.ready),
	.kind     (tokens.token_kind),
	.length   (tokens.lexeme_length),
	.line     (tokens.line_number),
	.last     (tokens.last_of_run)
);
